// ===== rtl/ckb_pkg.sv =====
// Shared types, constants and helpers for the color-key sprite blitter.
// No dependencies.
package ckb_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int CNT_W       = $clog2(MAX_SIDE);
	localparam int BYTE_W      = 8;
	localparam int COLOR_W     = 2 * BYTE_W;
	localparam int COORD_W     = 9;
	localparam int ORG_W       = 11;
	localparam int SPW_W       = 7;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	localparam logic [COLOR_W-1:0] KEY_RESET    = 16'hF81F;
	localparam logic [SPW_W-1:0]   SPW_RESET    = 7'd16;
	localparam logic [COORD_W-1:0] SCR_W_RESET  = 9'd160;
	localparam logic [COORD_W-1:0] SCR_H_RESET  = 9'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X      = 3'd0,
		CFG_ORIGIN_Y      = 3'd1,
		CFG_SPRITE_WIDTH  = 3'd2,
		CFG_KEY_COLOR     = 3'd3,
		CFG_SCREEN_WIDTH  = 3'd4,
		CFG_SCREEN_HEIGHT = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ORG_W-1:0] origin_x;
		logic signed [ORG_W-1:0] origin_y;
		logic [SPW_W-1:0]        sprite_width;
		logic [COLOR_W-1:0]      key_color;
		logic [COORD_W-1:0]      screen_width;
		logic [COORD_W-1:0]      screen_height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] screen_x;
		logic [COORD_W-1:0] screen_y;
		logic [COLOR_W-1:0] color_be;
		logic               seg_first;
		logic               seg_last;
	} result_t;

	// up to two results per pixel, r0 goes out first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
		return {c[BYTE_W-1:0], c[COLOR_W-1:BYTE_W]};
	endfunction

endpackage

// ===== rtl/ckb_pix.sv =====
// Pixel stage: input register, raster counters, visibility test and the held pixel.
// Depends on ckb_pkg.
module ckb_pix import ckb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] pixel_color,
	input  logic               sprite_end,
	input  logic               room,
	output push_t              push
);

	localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(MAX_SIDE - 1);
	localparam logic [SPW_W-1:0] W_MAX    = SPW_W'(MAX_SIDE);

	logic               valid_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               end_s1;

	logic [CNT_W-1:0]   col_q;
	logic [CNT_W-1:0]   row_q;
	logic               held_valid_q;
	logic [COORD_W-1:0] held_x_q;
	logic [COORD_W-1:0] held_y_q;
	logic [COLOR_W-1:0] held_color_q;
	logic               held_first_q;

	logic               go;
	logic [SPW_W-1:0]   w_eff;
	logic signed [ORG_W:0] sx;
	logic signed [ORG_W:0] sy;
	logic               vis;
	logic               row_end;
	logic               close_now;
	result_t            cur_res;
	result_t            held_res;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			color_s1 <= pixel_color;
			end_s1   <= sprite_end;
		end
	end

	always_comb begin
		if (cfg.sprite_width == '0) begin
			w_eff = SPW_W'(1);
		end else if (cfg.sprite_width > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = cfg.sprite_width;
		end
		sx = {cfg.origin_x[ORG_W-1], cfg.origin_x} + $signed({{(ORG_W+1-CNT_W){1'b0}}, col_q});
		sy = {cfg.origin_y[ORG_W-1], cfg.origin_y} + $signed({{(ORG_W+1-CNT_W){1'b0}}, row_q});
		vis = (color_s1 != cfg.key_color)
			&& !sx[ORG_W] && (sx[ORG_W-1:0] < {{(ORG_W-COORD_W){1'b0}}, cfg.screen_width})
			&& !sy[ORG_W] && (sy[ORG_W-1:0] < {{(ORG_W-COORD_W){1'b0}}, cfg.screen_height});
		row_end   = ({1'b0, col_q} + SPW_W'(1)) >= w_eff;
		close_now = row_end || end_s1;

		cur_res.screen_x  = sx[COORD_W-1:0];
		cur_res.screen_y  = sy[COORD_W-1:0];
		cur_res.color_be  = swap_bytes(color_s1);
		cur_res.seg_first = !held_valid_q;
		cur_res.seg_last  = 1'b1;

		held_res.screen_x  = held_x_q;
		held_res.screen_y  = held_y_q;
		held_res.color_be  = swap_bytes(held_color_q);
		held_res.seg_first = held_first_q;
		held_res.seg_last  = !vis;

		push.r0 = held_valid_q ? held_res : cur_res;
		push.r1 = cur_res;
		if (go) begin
			push.n = {1'b0, held_valid_q} + {1'b0, vis && close_now};
		end else begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			held_valid_q <= 1'b0;
		end else if (go) begin
			held_valid_q <= vis && !close_now;
			if (end_s1) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= (row_q == ROW_LAST) ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && vis && !close_now) begin
			held_x_q     <= sx[COORD_W-1:0];
			held_y_q     <= sy[COORD_W-1:0];
			held_color_q <= color_s1;
			held_first_q <= !held_valid_q;
		end
	end

	a_two_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> held_valid_q && push.r1.seg_last)
		else $error("two results without a held pixel");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && end_s1 |=> col_q == '0 && row_q == '0 && !held_valid_q)
		else $error("sprite end left state behind");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> push.n == 2'd0)
		else $error("results pushed without a pixel");

endmodule

// ===== rtl/ckb_ofifo.sv =====
// Result queue: takes up to two results per cycle, hands out one beat per cycle while out_ready is high.
// Depends on ckb_pkg.
module ckb_ofifo import ckb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	result_t                mem_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_q;
	logic [OFIFO_PTR_W-1:0] rd_q;
	logic [OFIFO_CNT_W-1:0] cnt_q;
	logic                   pop;
	logic [OFIFO_PTR_W-1:0] wr_next;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2);
	assign head      = mem_q[rd_q];
	assign wr_next   = wr_q + OFIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OFIFO_PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + OFIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + OFIFO_CNT_W'(push.n) - OFIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2))
		else $error("push into a full queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OFIFO_CNT_W'(OFIFO_DEPTH))
		else $error("queue count out of range");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_q == rd_q)
		else $error("empty queue with split pointers");

endmodule

// ===== rtl/color_key_sprite_blitter.sv =====
// Path: a visible pixel passes the input register and the result queue, or
// waits as the held pixel until the next pixel shows whether it closes its segment.
// Throughput: one pixel per cycle; a 4-entry result queue absorbs the
// two-result beats and input stalls when fewer than two entries are free.
// Reset: config returns to defaults; counters, held pixel and queue clear.
// Depends on ckb_pkg, ckb_pix, ckb_ofifo.
module color_key_sprite_blitter import ckb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic                  sprite_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    screen_x,
	output logic [COORD_W-1:0]    screen_y,
	output logic [COLOR_W-1:0]    color_be,
	output logic                  seg_first,
	output logic                  seg_last
);

	cfg_t    cfg_q;
	push_t   push;
	logic    room;
	result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.sprite_width  <= SPW_RESET;
			cfg_q.key_color     <= KEY_RESET;
			cfg_q.screen_width  <= SCR_W_RESET;
			cfg_q.screen_height <= SCR_H_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data[ORG_W-1:0];
				CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data[ORG_W-1:0];
				CFG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[SPW_W-1:0];
				CFG_KEY_COLOR:     cfg_q.key_color     <= cfg_data[COLOR_W-1:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[COORD_W-1:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ckb_pix u_pix (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_color (pixel_color),
		.sprite_end  (sprite_end),
		.room        (room),
		.push        (push)
	);

	ckb_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign screen_x  = head.screen_x;
	assign screen_y  = head.screen_y;
	assign color_be  = head.color_be;
	assign seg_first = head.seg_first;
	assign seg_last  = head.seg_last;

endmodule

// ===== tb/color_key_sprite_blitter_test.sv =====
// Testbench for color_key_sprite_blitter: streams sprites through the blitter,
// predicts every emitted pixel in a local model and checks them in order.
// Depends on ckb_pkg and the blitter RTL.
`timescale 1ns / 1ps

module color_key_sprite_blitter_test;
	import ckb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PIXELS = 560;
	localparam int MAX_GAP       = 10;

	localparam logic [COLOR_W-1:0] DIRECTED_PIXELS [21] = '{
		16'h0000, 16'hFFFF, KEY_RESET, 16'h0001, 16'h8000, KEY_RESET, KEY_RESET,
		16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, KEY_RESET, 16'h1234, 16'hFEDC,
		16'h7FFF, 16'hF81E, 16'hABCD, KEY_RESET, 16'h0F0F, 16'hF0F0, 16'h1111
	};

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [COLOR_W-1:0]    pixel_color = '0;
	logic                  sprite_end  = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [COORD_W-1:0]    screen_x;
	logic [COORD_W-1:0]    screen_y;
	logic [COLOR_W-1:0]    color_be;
	logic                  seg_first;
	logic                  seg_last;

	color_key_sprite_blitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_color(pixel_color),
		.sprite_end(sprite_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.screen_x(screen_x),
		.screen_y(screen_y),
		.color_be(color_be),
		.seg_first(seg_first),
		.seg_last(seg_last)
	);

	// model copy of the registers
	logic signed [ORG_W-1:0] org_x   = '0;
	logic signed [ORG_W-1:0] org_y   = '0;
	logic [SPW_W-1:0]        spr_w   = SPW_RESET;
	logic [COLOR_W-1:0]      key_rgb = KEY_RESET;
	logic [COORD_W-1:0]      scr_w   = SCR_W_RESET;
	logic [COORD_W-1:0]      scr_h   = SCR_H_RESET;

	// model copy of the blitter state
	int      col_cnt    = 0;
	int      row_cnt    = 0;
	bit      hold_valid = 1'b0;
	result_t hold_pix   = '0;

	result_t pending_pixels[$];
	int      errors     = 0;
	int      cycles     = 0;
	bit      send_idle  = 1'b1;
	bit      recv_idle  = 1'b1;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int eff_width();
		int w;
		w = spr_w;
		if (w == 0) w = 1;
		if (w > MAX_SIDE) w = MAX_SIDE;
		return w;
	endfunction

	function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_ORIGIN_X:      org_x   = d[ORG_W-1:0];
			CFG_ORIGIN_Y:      org_y   = d[ORG_W-1:0];
			CFG_SPRITE_WIDTH:  spr_w   = d[SPW_W-1:0];
			CFG_KEY_COLOR:     key_rgb = d[COLOR_W-1:0];
			CFG_SCREEN_WIDTH:  scr_w   = d[COORD_W-1:0];
			CFG_SCREEN_HEIGHT: scr_h   = d[COORD_W-1:0];
			default: ;
		endcase
	endfunction

	// works out the pixels a sprite beat releases; a visible pixel that may
	// still grow its segment waits in hold_pix
	function automatic void blit_pixel(input logic [COLOR_W-1:0] c, input bit is_end);
		int      sx;
		int      sy;
		bit      vis;
		bit      row_end;
		bit      had_hold;
		result_t r;
		sx = int'(org_x) + col_cnt;
		sy = int'(org_y) + row_cnt;
		vis = (c != key_rgb) && sx >= 0 && sx < int'(scr_w) && sy >= 0 && sy < int'(scr_h);
		row_end = col_cnt + 1 >= eff_width();
		had_hold = hold_valid;
		if (hold_valid) begin
			r = hold_pix;
			r.seg_last = !vis;
			pending_pixels.push_back(r);
			hold_valid = 1'b0;
		end
		if (vis) begin
			r.screen_x = sx[COORD_W-1:0];
			r.screen_y = sy[COORD_W-1:0];
			r.color_be = {c[BYTE_W-1:0], c[COLOR_W-1:BYTE_W]};
			r.seg_first = !had_hold;
			r.seg_last = 1'b1;
			if (row_end || is_end) begin
				pending_pixels.push_back(r);
			end else begin
				hold_pix = r;
				hold_valid = 1'b1;
			end
		end
		if (is_end) begin
			col_cnt = 0;
			row_cnt = 0;
		end else if (row_end) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= MAX_SIDE) ? 0 : row_cnt + 1;
		end else begin
			col_cnt++;
		end
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, d);
	endtask

	task automatic send_pixel(input logic [COLOR_W-1:0] c, input bit is_end);
		int gap;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pixel_color <= c;
		sprite_end <= is_end;
		do @(posedge clk); while (!in_ready);
		blit_pixel(c, is_end);
	endtask

	// stop sending until every predicted pixel is out and the pipe is empty
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COLOR_W-1:0] opaque_color();
		logic [COLOR_W-1:0] c;
		c = COLOR_W'($urandom);
		if (c == key_rgb) c = c ^ 16'h0001;
		return c;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] origin_word(input int v);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[ORG_W-1:0] = v[ORG_W-1:0];
		return d;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_idx_t idx);
		logic [CFG_DATA_W-1:0] d;
		int                    v;
		int                    pick;
		d = CFG_DATA_W'($urandom);
		pick = $urandom_range(0, 5);
		case (idx)
			CFG_ORIGIN_X, CFG_ORIGIN_Y: begin
				v = (pick == 0) ? -1024 : (pick == 1) ? 1023 : $urandom_range(0, 240) - 40;
				d[ORG_W-1:0] = v[ORG_W-1:0];
			end
			CFG_SPRITE_WIDTH: begin
				v = (pick == 0) ? 0 : (pick == 1) ? 127 : (pick == 2) ? MAX_SIDE :
					(pick == 3) ? 1 : $urandom_range(2, 20);
				d[SPW_W-1:0] = v[SPW_W-1:0];
			end
			CFG_KEY_COLOR: begin
				if (pick == 0) d = 16'h0000;
				else if (pick == 1) d = 16'hFFFF;
			end
			default: begin
				v = (pick == 0) ? 0 : (pick == 1) ? 511 : (pick == 2) ? 1 : $urandom_range(1, 200);
				d[COORD_W-1:0] = v[COORD_W-1:0];
			end
		endcase
		return d;
	endfunction

	task automatic test_default_row();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		// one full 16-wide row, then a short row closed by the sprite end, then a one-pixel sprite
		foreach (DIRECTED_PIXELS[i])
			send_pixel(DIRECTED_PIXELS[i], i >= 19);
	endtask

	task automatic test_clipping();
		wait_drained();
		write_reg(CFG_ORIGIN_X, origin_word(-2));
		write_reg(CFG_ORIGIN_Y, origin_word(-1));
		write_reg(CFG_SPRITE_WIDTH, 16'd6);
		write_reg(CFG_SCREEN_WIDTH, 16'd3);
		write_reg(CFG_SCREEN_HEIGHT, 16'd2);
		for (int i = 0; i < 24; i++)
			send_pixel(i == 8 ? key_rgb : opaque_color(), i == 23);
		wait_drained();
		write_reg(CFG_SCREEN_WIDTH, 16'd160);
		write_reg(CFG_SCREEN_HEIGHT, 16'd128);
		write_reg(CFG_ORIGIN_X, origin_word(-1024));
		for (int i = 0; i < 3; i++)
			send_pixel(opaque_color(), i == 2);
		wait_drained();
		write_reg(CFG_ORIGIN_X, origin_word(1023));
		write_reg(CFG_ORIGIN_Y, origin_word(1023));
		for (int i = 0; i < 3; i++)
			send_pixel(opaque_color(), i == 2);
	endtask

	task automatic test_width_shrink_mid_row();
		wait_drained();
		write_reg(CFG_ORIGIN_X, 16'd0);
		write_reg(CFG_ORIGIN_Y, 16'd0);
		write_reg(CFG_SPRITE_WIDTH, 16'd8);
		for (int i = 0; i < 5; i++)
			send_pixel(opaque_color(), 1'b0);
		// column already past the new width: next pixel closes the row
		wait_drained();
		write_reg(CFG_SPRITE_WIDTH, 16'd3);
		for (int i = 0; i < 4; i++)
			send_pixel(opaque_color(), i == 3);
	endtask

	task automatic test_row_wrap();
		wait_drained();
		write_reg(CFG_SPRITE_WIDTH, 16'd0);
		write_reg(CFG_SCREEN_HEIGHT, 16'd511);
		for (int i = 0; i < 70; i++)
			send_pixel($urandom_range(0, 3) == 0 ? key_rgb : opaque_color(), i == 69);
		wait_drained();
		write_reg(CFG_SPRITE_WIDTH, 16'd127);
		write_reg(CFG_ORIGIN_X, origin_word(-2));
		for (int i = 0; i < 66; i++)
			send_pixel($urandom_range(0, 4) == 0 ? key_rgb : opaque_color(), i == 65);
	endtask

	task automatic test_zero_screen();
		wait_drained();
		write_reg(CFG_ORIGIN_X, 16'd0);
		write_reg(CFG_SPRITE_WIDTH, 16'd4);
		write_reg(CFG_SCREEN_WIDTH, 16'd0);
		for (int i = 0; i < 6; i++)
			send_pixel(opaque_color(), 1'b0);
		wait_drained();
		write_reg(CFG_SCREEN_WIDTH, 16'd160);
		write_reg(CFG_SCREEN_HEIGHT, 16'd0);
		for (int i = 0; i < 6; i++)
			send_pixel(opaque_color(), i == 5);
		wait_drained();
		write_reg(CFG_SCREEN_HEIGHT, 16'd128);
	endtask

	task automatic test_random_phases();
		int sent;
		int phase;
		int w;
		int h;
		int n;
		int key_share;
		bit no_end;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			wait_drained();
			for (int i = 0; i <= int'(CFG_SCREEN_HEIGHT); i++)
				if (phase == 0 || $urandom_range(0, 1) == 1)
					write_reg(cfg_idx_t'(i), pick_reg_value(cfg_idx_t'(i)));
			send_idle = 1'($urandom_range(0, 1));
			recv_idle = 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 3)) begin
				w = eff_width();
				h = $urandom_range(1, (120 / w > 6) ? 6 : (120 / w < 1 ? 1 : 120 / w));
				n = w * h;
				if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
				no_end = $urandom_range(0, 9) == 0;
				key_share = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					send_pixel($urandom_range(0, 3) < key_share ? key_rgb :
						COLOR_W'($urandom), (i == n - 1) && !no_end);
				sent += n;
			end
			phase++;
		end
		send_pixel(COLOR_W'($urandom), 1'b1);
	endtask

	// result side: random stall before every beat while recv_idle is set
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel at x=%0d y=%0d", screen_x, screen_y);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (screen_x !== want.screen_x) begin
					$error("screen_x: expected %0d, got %0d", want.screen_x, screen_x);
					errors++;
				end
				if (screen_y !== want.screen_y) begin
					$error("screen_y: expected %0d, got %0d", want.screen_y, screen_y);
					errors++;
				end
				if (color_be !== want.color_be) begin
					$error("color_be: expected %h, got %h", want.color_be, color_be);
					errors++;
				end
				if (seg_first !== want.seg_first) begin
					$error("seg_first: expected %b, got %b", want.seg_first, seg_first);
					errors++;
				end
				if (seg_last !== want.seg_last) begin
					$error("seg_last: expected %b, got %b", want.seg_last, seg_last);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_row();
		test_clipping();
		test_width_shrink_mid_row();
		test_row_wrap();
		test_zero_screen();
		test_random_phases();
		wait_drained();
		if (pending_pixels.size() == 0 && errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ckb_pkg.sv
rtl/ckb_pix.sv
rtl/ckb_ofifo.sv
rtl/color_key_sprite_blitter.sv
tb/color_key_sprite_blitter_test.sv
